// ===== rtl/core/ite_pkg.sv =====
package ite_pkg;

  localparam int Capacity = 32;
  localparam int CountW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_FIND_OVL   = 3'd1,
    OP_FIND_AFTER = 3'd2,
    OP_NEXT       = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_EXEC = 2'b10
  } phase_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] start_req;
    logic [63:0] size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] entry_start;
    logic [63:0] entry_size;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] start;
    logic [63:0] len;
  } cell_data_t;

  typedef struct packed {
    logic        capture;
    logic [63:0] pt;
    logic [64:0] pt_end;
  } cell_cmp_t;

  typedef struct packed {
    logic        clear;
    logic        load;
    logic        from_left;
    logic        from_right;
    logic [63:0] new_start;
    logic [63:0] new_len;
  } cell_upd_t;

  typedef struct packed {
    logic ovl;
    logic ins;
    logic after;
    logic eq;
  } cell_flags_t;

  function automatic logic [Capacity-1:0] lowbit(input logic [Capacity-1:0] f);
    return f & (~f + Capacity'(1));
  endfunction

  function automatic logic [Capacity-1:0] from_bit(input logic [Capacity-1:0] lb);
    return ~(lb - Capacity'(1));
  endfunction

endpackage

// ===== rtl/core/interval_table_engine_top.sv =====
// Ordered table of up to 32 non-overlapping extents held in a row of cells,
// one extent per cell, kept sorted and packed from cell 0. An item is taken
// when start is high and busy is low; busy is then high for one cycle and the
// item's single result appears with done_o for one cycle right after it, so
// no item is taken in the execute cycle. In the accept cycle every cell compares
// its extent with the request; in the next cycle a priority pick chooses the
// answering cell and the row shifts by one cell to insert or remove. Results
// cannot be held off and must be taken when done_o is high.
module interval_table_engine_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ite_pkg::req_t req_i,
  output logic          done_o,
  output ite_pkg::rsp_t rsp_o
);

  localparam int Cap = ite_pkg::Capacity;

  ite_pkg::phase_e      phase_q, phase_d;
  ite_pkg::req_t        req_q;
  ite_pkg::rsp_t        rsp_q, rsp_d;
  logic                 done_q;
  logic [ite_pkg::CountW-1:0] count_q, count_d;

  ite_pkg::cell_cmp_t   cmp;
  ite_pkg::cell_upd_t   upd [Cap];
  ite_pkg::cell_data_t  data_a [Cap];
  ite_pkg::cell_flags_t flags_a [Cap];

  logic [Cap-1:0] val_v, ovl_v, ins_v, aft_v, eq_v;
  logic [Cap-1:0] sel_v, load_v, left_v, right_v;
  logic [Cap-1:0] ins_lb, rem_lb;
  logic [63:0]    sel_start, sel_len;
  logic           clr, accept, exec, full;

  assign accept = start && !busy;
  assign exec   = (phase_q == ite_pkg::PH_EXEC);
  assign busy   = exec;
  assign full   = (count_q == ite_pkg::CountW'(Cap));

  assign cmp.capture = accept;
  assign cmp.pt      = req_i.start_req;
  assign cmp.pt_end  = {1'b0, req_i.start_req} + {1'b0, req_i.size};

  for (genvar k = 0; k < Cap; k++) begin : g_cell
    ite_pkg::cell_data_t left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = data_a[k-1];
    end
    if (k == Cap - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = data_a[k+1];
    end

    assign upd[k] = '{clear: clr, load: load_v[k], from_left: left_v[k],
                      from_right: right_v[k], new_start: req_q.start_req,
                      new_len: req_q.size};

    ite_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmp_i   (cmp),
      .upd_i   (upd[k]),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_a[k]),
      .flags_o (flags_a[k])
    );

    assign val_v[k] = data_a[k].valid;
    assign ovl_v[k] = flags_a[k].ovl;
    assign ins_v[k] = flags_a[k].ins;
    assign aft_v[k] = flags_a[k].after;
    assign eq_v[k]  = flags_a[k].eq;
  end

  assign ins_lb = ite_pkg::lowbit(ins_v | ~val_v);
  assign rem_lb = ite_pkg::lowbit(eq_v);

  always_comb begin
    sel_v = '0;
    if (exec) begin
      case (req_q.op)
        ite_pkg::OP_INSERT, ite_pkg::OP_FIND_OVL: begin
          sel_v = ite_pkg::lowbit(ovl_v);
        end
        ite_pkg::OP_FIND_AFTER: begin
          sel_v = ite_pkg::lowbit(aft_v);
        end
        ite_pkg::OP_NEXT: begin
          sel_v = (rem_lb << 1) & val_v;
        end
        ite_pkg::OP_REMOVE: begin
          sel_v = rem_lb;
        end
        default: begin
          sel_v = '0;
        end
      endcase
    end
  end

  always_comb begin
    sel_start = '0;
    sel_len   = '0;
    for (int k = 0; k < Cap; k++) begin
      sel_start = sel_start | (data_a[k].start & {64{sel_v[k]}});
      sel_len   = sel_len | (data_a[k].len & {64{sel_v[k]}});
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    rsp_d   = rsp_q;
    load_v  = '0;
    left_v  = '0;
    right_v = '0;
    clr     = 1'b0;
    if (accept) begin
      phase_d = ite_pkg::PH_EXEC;
    end else if (exec) begin
      phase_d = ite_pkg::PH_IDLE;
      rsp_d   = '{status: ite_pkg::ST_NONE, entry_start: '0, entry_size: '0};
      case (req_q.op)
        ite_pkg::OP_INSERT: begin
          if (|ovl_v) begin
            rsp_d = '{status: ite_pkg::ST_OVERLAP, entry_start: sel_start,
                      entry_size: sel_len};
          end else if (full) begin
            rsp_d.status = ite_pkg::ST_FULL;
          end else begin
            load_v  = ins_lb;
            left_v  = ite_pkg::from_bit(ins_lb) & ~ins_lb;
            count_d = count_q + ite_pkg::CountW'(1);
            rsp_d   = '{status: ite_pkg::ST_OK, entry_start: req_q.start_req,
                        entry_size: req_q.size};
          end
        end
        ite_pkg::OP_FIND_OVL: begin
          if (|ovl_v) begin
            rsp_d = '{status: ite_pkg::ST_OK, entry_start: sel_start,
                      entry_size: sel_len};
          end
        end
        ite_pkg::OP_FIND_AFTER: begin
          if (|aft_v) begin
            rsp_d = '{status: ite_pkg::ST_OK, entry_start: sel_start,
                      entry_size: sel_len};
          end
        end
        ite_pkg::OP_NEXT: begin
          if (|sel_v) begin
            rsp_d = '{status: ite_pkg::ST_OK, entry_start: sel_start,
                      entry_size: sel_len};
          end
        end
        ite_pkg::OP_REMOVE: begin
          if (|eq_v) begin
            right_v = ite_pkg::from_bit(rem_lb);
            count_d = count_q - ite_pkg::CountW'(1);
            rsp_d   = '{status: ite_pkg::ST_OK, entry_start: sel_start,
                        entry_size: sel_len};
          end
        end
        ite_pkg::OP_CLEAR: begin
          clr          = 1'b1;
          count_d      = '0;
          rsp_d.status = ite_pkg::ST_OK;
        end
        default: begin
          rsp_d.status = ite_pkg::ST_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ite_pkg::PH_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      done_q  <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) == $countones(val_v))
    else $error("entry count differs from the number of valid cells");

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_v & (val_v + Cap'(1))) == '0)
    else $error("valid cells are not packed from cell zero");

  a_one_cycle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("no result strobe after the execute cycle");

  a_no_shift_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |-> (load_v == '0) && (left_v == '0) && (right_v == '0) && !clr)
    else $error("table changed outside the execute cycle");

endmodule

// ===== rtl/core/ite_cell.sv =====
module ite_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ite_pkg::cell_cmp_t  cmp_i,
  input  ite_pkg::cell_upd_t  upd_i,
  input  ite_pkg::cell_data_t left_i,
  input  ite_pkg::cell_data_t right_i,
  output ite_pkg::cell_data_t data_o,
  output ite_pkg::cell_flags_t flags_o
);

  logic                 valid_q, valid_d;
  logic [63:0]          start_q, start_d;
  logic [63:0]          len_q, len_d;
  ite_pkg::cell_flags_t flags_q, flags_d;
  logic [64:0]          end_w;

  assign end_w = {1'b0, start_q} + {1'b0, len_q};

  always_comb begin
    flags_d = flags_q;
    if (cmp_i.capture) begin
      flags_d.ovl   = valid_q && (cmp_i.pt_end > {1'b0, start_q}) && (end_w > {1'b0, cmp_i.pt});
      flags_d.ins   = valid_q && (cmp_i.pt_end <= {1'b0, start_q});
      flags_d.after = valid_q && (end_w > {1'b0, cmp_i.pt});
      flags_d.eq    = valid_q && (start_q == cmp_i.pt);
    end
  end

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    len_d   = len_q;
    if (upd_i.clear) begin
      valid_d = 1'b0;
    end else if (upd_i.load) begin
      valid_d = 1'b1;
      start_d = upd_i.new_start;
      len_d   = upd_i.new_len;
    end else if (upd_i.from_left) begin
      valid_d = left_i.valid;
      start_d = left_i.start;
      len_d   = left_i.len;
    end else if (upd_i.from_right) begin
      valid_d = right_i.valid;
      start_d = right_i.start;
      len_d   = right_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flags_q <= '0;
    end else begin
      valid_q <= valid_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
  end

  assign data_o  = '{valid: valid_q, start: start_q, len: len_q};
  assign flags_o = flags_q;

endmodule
